// File: rtl/core/two_level_thread_scheduler_assert.svh
// Assertion macros used by the scheduler RTL.
`ifndef TWO_LEVEL_THREAD_SCHEDULER_ASSERT_SVH
`define TWO_LEVEL_THREAD_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on the rising edge, ignored while reset is high.
`define TLTS_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on the rising edge, also during reset.
`define TLTS_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLTS_ASSERT_RST(lbl, clk, rst, prop, msg)
`define TLTS_ASSERT(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/tlts_pkg.sv
`default_nettype none
package tlts_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int OUT_SLOT_W = 4;
  localparam logic [7:0] QUANTUM_RESET = 8'd10;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_CREATE = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_EXIT   = 3'd3,
    MODE_WAKE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_DONE       = 2'd2,
    STATUS_EMPTY_WAKE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EX   = 4'b0100,
    S_W2   = 4'b1000
  } seq_state_t;

endpackage
`default_nettype wire

// File: rtl/core/tlts_fifo.sv
`default_nettype none
module tlts_fifo import tlts_pkg::*; #(
  parameter int DEPTH = SLOTS_DEFAULT,
  parameter int DW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic      [DW-1:0] head_data,
  output logic               empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [IW-1:0] tail;
  logic          full;
  logic          push_ok;

  // Locate the tail slot modulo the depth
  assign tail_sum  = (CW+1)'(head) + (CW+1)'(count);
  assign tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
  assign tail      = tail_wrap[IW-1:0];
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign push_ok   = push && (!full || pop);

  // Write at the tail, read the head every cycle
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= push_data;
    end
    head_data <= mem[head];
  end

  // Advance head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push_ok && !pop) begin
        count <= count + 1'b1;
      end else if (!push_ok && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tlts_slot_table.sv
`default_nettype none
module tlts_slot_table import tlts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic      [7:0]               rd_ticks,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  wire logic [7:0]               wr_data,
  input  wire logic                     alloc_en,
  input  wire logic                     rel_en,
  input  wire logic [$clog2(SLOTS)-1:0] rel_idx,
  output logic                          free_any,
  output logic      [$clog2(SLOTS)-1:0] free_idx
);

  localparam int SW = $clog2(SLOTS);

  logic [7:0]       mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] free_map;
  logic [7:0]       mem_q;
  logic             valid_q;
  logic [SW-1:0]    low_idx;
  logic             low_any;

  // Ticks memory, read registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  // Unwritten entries hold the reset quantum
  assign rd_ticks = valid_q ? mem_q : QUANTUM_RESET;

  // Find the lowest free slot
  always_comb begin
    low_idx = '0;
    low_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        low_idx = SW'(i);
        low_any = 1'b1;
      end
    end
  end

  // Track free slots; slot zero starts in use
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= {{(SLOTS-1){1'b1}}, 1'b0};
      free_any <= 1'b0;
      free_idx <= '0;
    end else begin
      if (alloc_en) begin
        free_map[free_idx] <= 1'b0;
      end
      if (rel_en) begin
        free_map[rel_idx] <= 1'b1;
      end
      free_any <= low_any;
      free_idx <= low_idx;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/two_level_thread_scheduler.sv
// An event passes through the read and execute states to its result, which is
// registered at the end of execute; an event that rewrites two tick counters does
// the second write in the cycle after execute, while the result already waits.
// Events are handled one at a time: a new event is taken only in the idle state
// and only once the previous result has been taken.
// Reset: slot 0 runs, all other slots free, queues empty, quantum 10.
`default_nettype none
`include "two_level_thread_scheduler_assert.svh"
module two_level_thread_scheduler import tlts_pkg::*; #(
  parameter int THREAD_SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] priority_req
  input  wire logic [2:0]  s_tuser,   // [2:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [3:0] running_slot, [4] running_idle, [5] switched, [9:6] created_slot,
  // [11:10] status, [12] running_priority
  output logic      [15:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int SW = $clog2(THREAD_SLOTS);

  seq_state_t    state;
  mode_t         mode_q;
  logic          pri_q;
  logic [SW-1:0] cur;
  logic          cur_pri;
  logic          idle;
  logic          done;
  logic [7:0]    quantum;
  logic [SW-1:0] w2_addr;

  logic [SW-1:0] cur_next;
  logic          cur_pri_next;
  logic          idle_next;
  logic          done_next;
  logic          w2_need;
  logic          sw;
  logic [SW-1:0] created;
  status_t       status_c;
  logic [15:0]   m_tdata_next;

  logic          h_push, h_pop, h_empty;
  logic          l_push, l_pop, l_empty;
  logic          w_push, w_pop, w_empty;
  logic [SW-1:0] h_din, h_dout, l_din, l_dout;
  logic [SW:0]   w_dout;

  logic          ex_we;
  logic [SW-1:0] ex_addr;
  logic [7:0]    ex_data;
  logic          t_we;
  logic [SW-1:0] t_addr;
  logic [7:0]    t_data;
  logic [7:0]    ticks_rd;
  logic [7:0]    tick_dec;
  logic          alloc_en, rel_en;
  logic          free_any;
  logic [SW-1:0] free_idx;
  logic          accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign tick_dec = ticks_rd - 8'd1;

  tlts_fifo #(.DEPTH(THREAD_SLOTS), .DW(SW)) u_high (
    .clk, .rst, .push(h_push), .push_data(h_din), .pop(h_pop),
    .head_data(h_dout), .empty(h_empty)
  );

  tlts_fifo #(.DEPTH(THREAD_SLOTS), .DW(SW)) u_low (
    .clk, .rst, .push(l_push), .push_data(l_din), .pop(l_pop),
    .head_data(l_dout), .empty(l_empty)
  );

  // Wait queue entries carry the slot priority on top
  tlts_fifo #(.DEPTH(THREAD_SLOTS), .DW(SW + 1)) u_wait (
    .clk, .rst, .push(w_push), .push_data({cur_pri, cur}), .pop(w_pop),
    .head_data(w_dout), .empty(w_empty)
  );

  tlts_slot_table #(.SLOTS(THREAD_SLOTS)) u_table (
    .clk, .rst, .rd_addr(cur), .rd_ticks(ticks_rd),
    .wr_en(t_we), .wr_addr(t_addr), .wr_data(t_data),
    .alloc_en, .rel_en, .rel_idx(cur), .free_any, .free_idx
  );

  // Ticks write port: first write in execute, deferred write after it
  assign t_we   = ex_we || (state == S_W2);
  assign t_addr = (state == S_W2) ? w2_addr : ex_addr;
  assign t_data = (state == S_W2) ? quantum : ex_data;

  // Execute one event on the values read from the memories
  always_comb begin
    cur_next     = cur;
    cur_pri_next = cur_pri;
    idle_next    = idle;
    done_next    = done;
    w2_need      = 1'b0;
    sw           = 1'b0;
    created      = '0;
    status_c     = STATUS_OK;
    h_push = 1'b0; h_pop = 1'b0; h_din = free_idx;
    l_push = 1'b0; l_pop = 1'b0; l_din = cur;
    w_push = 1'b0; w_pop = 1'b0;
    ex_we = 1'b0; ex_addr = cur; ex_data = quantum;
    alloc_en = 1'b0; rel_en = 1'b0;
    if (state == S_EX && !done) begin
      unique case (mode_q)
        MODE_TICK: begin
          if (idle) begin
            if (!h_empty) begin
              h_pop = 1'b1; cur_next = h_dout; cur_pri_next = 1'b1;
              idle_next = 1'b0; sw = 1'b1;
            end else if (!l_empty) begin
              l_pop = 1'b1; cur_next = l_dout; cur_pri_next = 1'b0;
              idle_next = 1'b0; sw = 1'b1;
            end else if (w_empty) begin
              done_next = 1'b1;
            end
          end else if (!cur_pri) begin
            ex_we = 1'b1;
            if (tick_dec == 8'd0) begin
              if (!l_empty) begin
                l_pop = 1'b1; l_push = 1'b1;
                cur_next = l_dout; sw = 1'b1;
              end
            end else begin
              ex_data = tick_dec;
            end
          end
        end
        MODE_CREATE: begin
          if (!free_any) begin
            status_c = STATUS_FULL;
          end else begin
            alloc_en = 1'b1;
            ex_we = 1'b1; ex_addr = free_idx;
            created = free_idx;
            if (!pri_q) begin
              l_push = 1'b1; l_din = free_idx;
            end else if (idle || !cur_pri) begin
              if (!idle) begin
                w2_need = 1'b1; l_push = 1'b1;
              end
              cur_next = free_idx; cur_pri_next = 1'b1;
              idle_next = 1'b0; sw = 1'b1;
            end else begin
              h_push = 1'b1;
            end
          end
        end
        MODE_BLOCK: begin
          if (!idle) begin
            w_push = 1'b1; sw = 1'b1;
            if (!h_empty) begin
              h_pop = 1'b1; cur_next = h_dout; cur_pri_next = 1'b1;
            end else if (!l_empty) begin
              l_pop = 1'b1; cur_next = l_dout; cur_pri_next = 1'b0;
              ex_we = 1'b1;
            end else begin
              idle_next = 1'b1;
            end
          end
        end
        MODE_EXIT: begin
          if (!idle) begin
            rel_en = 1'b1;
            if (!h_empty) begin
              h_pop = 1'b1; cur_next = h_dout; cur_pri_next = 1'b1; sw = 1'b1;
            end else if (!l_empty) begin
              l_pop = 1'b1; cur_next = l_dout; cur_pri_next = 1'b0; sw = 1'b1;
            end else if (!w_empty) begin
              idle_next = 1'b1; sw = 1'b1;
            end else begin
              done_next = 1'b1; idle_next = 1'b1;
            end
          end
        end
        MODE_WAKE: begin
          if (w_empty) begin
            status_c = STATUS_EMPTY_WAKE;
          end else begin
            w_pop = 1'b1;
            if (!w_dout[SW]) begin
              l_push = 1'b1; l_din = w_dout[SW-1:0];
            end else if (!idle && cur_pri) begin
              h_push = 1'b1; h_din = w_dout[SW-1:0];
            end else begin
              if (!idle) begin
                ex_we = 1'b1; l_push = 1'b1;
              end
              cur_next = w_dout[SW-1:0]; cur_pri_next = 1'b1;
              idle_next = 1'b0; sw = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pack the result
  always_comb begin
    if (done_next) begin
      m_tdata_next = {3'b000, 1'b0, STATUS_DONE, 4'b0000, 1'b0, 1'b1, 4'b0000};
    end else begin
      m_tdata_next = {3'b000, (!idle_next && cur_pri_next), status_c,
                      OUT_SLOT_W'(created), sw, idle_next,
                      idle_next ? 4'b0000 : OUT_SLOT_W'(cur_next)};
    end
  end

  // Hold the quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  // Sequence one event: read, execute, optional second write
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur      <= '0;
      cur_pri  <= 1'b0;
      idle     <= 1'b0;
      done     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          cur      <= cur_next;
          cur_pri  <= cur_pri_next;
          idle     <= idle_next;
          done     <= done_next;
          m_tvalid <= 1'b1;
          state    <= w2_need ? S_W2 : S_IDLE;
        end
        S_W2: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the event and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode_t'(s_tuser);
      pri_q  <= s_tdata[0];
    end
    if (state == S_EX) begin
      m_tdata <= m_tdata_next;
      w2_addr <= cur;
    end
  end

  `TLTS_ASSERT_RST(a_done_sticks, clk, rst, done |=> done, "finished state left before reset")
  `TLTS_ASSERT_RST(a_result_follows, clk, rst, (state == S_EX) |=> m_tvalid, "event gave no result")
  `TLTS_ASSERT_RST(a_no_overwrite, clk, rst, accept |-> !m_tvalid, "event taken over a pending result")
  `TLTS_ASSERT_RST(a_done_idle, clk, rst, done |-> idle, "finished without the idle flag")

endmodule
`default_nettype wire
